[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, geometry and codes for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	// Field widths
	localparam int ADDR_W    = 11;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CELL_W    = 16;
	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 2;

	// Derived addresses and limits
	localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] CELL_TOTAL = ADDR_W'(CELL_COUNT);
	localparam logic [ADDR_W-1:0] LAST_BASE  = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

	// Commands
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

	// Control characters
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// Reset contents of every cell: blank, white on black
	localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F20;
	localparam logic [COLOR_W-1:0] FG_RESET  = 4'hF;
	localparam logic [COLOR_W-1:0] BG_RESET  = 4'h0;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_CLEAR,
		ST_SCROLL,
		ST_FILL
	} state_t;

	// Build a cell from the colors and a character byte
	function automatic logic [CELL_W-1:0] make_cell(
		input logic [COLOR_W-1:0] bg,
		input logic [COLOR_W-1:0] fg,
		input logic [CHAR_W-1:0]  ch
	);
		make_cell = {bg, fg, ch};
	endfunction

endpackage

[rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell terminal engine: screen store, cursor, put/clear/read.
//
//   channel   signals                                   flow
//   -------   ---------------------------------------   -------------------
//   command   start, busy, cmd, char_code, cell_index   taken when start & !busy
//   result    done, cursor_*, cell_value, scrolled      one word, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  taken when valid & ready
//
// Clear sweeps the screen store one cell a cycle. A put that scrolls copies
// the store up one line through its one read port and one write port, then
// blanks the bottom line. After reset a clearing pass fills the store with
// blanks while busy is high; config writes are taken throughout. The
// receiver cannot stall: done is high one cycle.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [tcw_pkg::CMD_W-1:0]      cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]     cell_index,
	output logic                           done,
	output logic [tcw_pkg::ADDR_W-1:0]     cursor_position,
	output logic [tcw_pkg::COL_W-1:0]      cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
	output logic [tcw_pkg::CELL_W-1:0]     cell_value,
	output logic                           scrolled,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]    cfg_data
);
	import tcw_pkg::*;

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   cnt_q, cnt_d;
	logic [CMD_W-1:0]    cmd_q;
	logic [CHAR_W-1:0]   char_q;
	logic [ADDR_W-1:0]   idx_q;
	logic                rd_ok_q;
	logic [COL_W-1:0]    col_q, col_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [ADDR_W-1:0]   base_q, base_d;
	logic [COLOR_W-1:0]  fg_q, bg_q;

	logic                done_q;
	logic [ADDR_W-1:0]   pos_out_q;
	logic [COL_W-1:0]    col_out_q;
	logic [ROW_W-1:0]    row_out_q;
	logic [CELL_W-1:0]   cell_out_q;
	logic                scr_out_q;

	logic [CELL_W-1:0]   mem [CELL_COUNT];
	logic [CELL_W-1:0]   rd_data_s1;
	logic                wr_vld_s1, wr_vld_d;
	logic [ADDR_W-1:0]   wr_addr_s1;

	logic                we_c;
	logic [ADDR_W-1:0]   waddr_c, raddr_c;
	logic [CELL_W-1:0]   wdata_c;
	logic                fire_c, scr_c;
	logic [CELL_W-1:0]   cell_c;
	logic [CELL_W-1:0]   blank_c;
	logic [ADDR_W-1:0]   pos_now_c;
	logic                newrow_c;

	assign blank_c   = make_cell(bg_q, fg_q, CH_SPACE);
	assign pos_now_c = base_q + ADDR_W'(col_q);

	// Next state, cursor update and store port control
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		col_d    = col_q;
		row_d    = row_q;
		base_d   = base_q;
		we_c     = 1'b0;
		waddr_c  = cnt_q;
		wdata_c  = blank_c;
		raddr_c  = cnt_q + ROW_STEP;
		wr_vld_d = 1'b0;
		fire_c   = 1'b0;
		scr_c    = 1'b0;
		cell_c   = '0;
		newrow_c = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				we_c    = 1'b1;
				wdata_c = CELL_RESET;
				if (cnt_q == CELL_LAST) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				priority if (cmd_q == CMD_PUT) begin
					priority if (char_q == CH_NEWLINE) begin
						col_d    = '0;
						newrow_c = 1'b1;
					end else if (char_q == CH_RETURN) begin
						col_d = '0;
					end else if (char_q == CH_BACKSPACE) begin
						if (col_q != '0) begin
							col_d   = col_q - 1'b1;
							we_c    = 1'b1;
							waddr_c = pos_now_c - 1'b1;
						end
					end else begin
						we_c    = 1'b1;
						waddr_c = pos_now_c;
						wdata_c = make_cell(bg_q, fg_q, char_q);
						if (col_q == COL_LAST) begin
							col_d    = '0;
							newrow_c = 1'b1;
						end else begin
							col_d = col_q + 1'b1;
						end
					end
					// Step down a row, or scroll from the last row
					if (newrow_c && row_q == ROW_LAST) begin
						cnt_d   = '0;
						state_d = ST_SCROLL;
					end else begin
						if (newrow_c) begin
							row_d  = row_q + 1'b1;
							base_d = base_q + ROW_STEP;
						end
						fire_c  = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (cmd_q == CMD_CLEAR) begin
					cnt_d   = '0;
					col_d   = '0;
					row_d   = '0;
					base_d  = '0;
					state_d = ST_CLEAR;
				end else if (cmd_q == CMD_READ) begin
					raddr_c = idx_q;
					state_d = ST_READ;
				end else begin
					fire_c  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				fire_c  = 1'b1;
				cell_c  = rd_ok_q ? rd_data_s1 : '0;
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				we_c = 1'b1;
				if (cnt_q == CELL_LAST) begin
					cnt_d   = '0;
					fire_c  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SCROLL: begin
				// Read one line below, write back in the following cycle
				wr_vld_d = (cnt_q != LAST_BASE);
				we_c     = wr_vld_s1;
				waddr_c  = wr_addr_s1;
				wdata_c  = rd_data_s1;
				if (cnt_q == LAST_BASE) begin
					state_d = ST_FILL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FILL: begin
				we_c = 1'b1;
				if (cnt_q == CELL_LAST) begin
					cnt_d   = '0;
					fire_c  = 1'b1;
					scr_c   = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold sequencer, cursor and colors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cnt_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			base_q    <= '0;
			fg_q      <= FG_RESET;
			bg_q      <= BG_RESET;
			done_q    <= 1'b0;
			wr_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			col_q     <= col_d;
			row_q     <= row_d;
			base_q    <= base_d;
			done_q    <= fire_c;
			wr_vld_s1 <= wr_vld_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FG) begin
					fg_q <= cfg_data;
				end else if (cfg_index == REG_BG) begin
					bg_q <= cfg_data;
				end
			end
		end
	end

	// Capture the command word and the result word
	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			cmd_q   <= cmd;
			char_q  <= char_code;
			idx_q   <= cell_index;
			rd_ok_q <= (cell_index < CELL_TOTAL);
		end
		if (fire_c) begin
			pos_out_q  <= base_d + ADDR_W'(col_d);
			col_out_q  <= col_d;
			row_out_q  <= row_d;
			cell_out_q <= cell_c;
			scr_out_q  <= scr_c;
		end
		wr_addr_s1 <= cnt_q;
	end

	// Screen store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		rd_data_s1 <= mem[raddr_c];
	end

	assign busy            = (state_q != ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign cursor_position = pos_out_q;
	assign cursor_column   = col_out_q;
	assign cursor_row      = row_out_q;
	assign cell_value      = cell_out_q;
	assign scrolled        = scr_out_q;

`ifndef ASSERT_OFF
	// A result word follows only from a sequencer step, never from idle
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) != ST_IDLE)
		else $error("result word without a command in flight");

	// Reported cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cursor_column <= COL_LAST) && (cursor_row <= ROW_LAST))
		else $error("cursor off screen");

	// A scroll leaves the cursor on the last row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		done && scrolled |-> cursor_row == ROW_LAST)
		else $error("scroll left cursor off the last row");

	// Store is not written while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !we_c)
		else $error("store write while idle");
`endif

endmodule
